>>> src/aes_pkg.sv
// AES-128 package: payload types, S-box and GF helpers
package aes_pkg;

    localparam int unsigned NUM_ROUNDS = 10;

    localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW  = 2'd1;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } t_plain;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } t_cipher;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] tbl [256];
        tbl = '{
            8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
            8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
            8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
            8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
            8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
            8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
            8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
            8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
            8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
            8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
            8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
            8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
            8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
            8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
            8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
            8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
        };
        return tbl[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] t);
        return {sbox(t[31:24]), sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0])};
    endfunction

endpackage

>>> src/aes_lane.sv
// AES column lane: SubBytes on a shifted column, optional MixColumns, AddRoundKey
module aes_lane
    import aes_pkg::*;
(
    input  logic [31:0] i_col,
    input  logic        i_mix,
    input  logic [31:0] i_rk,
    output logic [31:0] o_col
);
    logic [7:0] a0, a1, a2, a3, all;
    logic [31:0] mixed;

    always_comb begin
        a0 = sbox(i_col[31:24]);
        a1 = sbox(i_col[23:16]);
        a2 = sbox(i_col[15:8]);
        a3 = sbox(i_col[7:0]);
        all = a0 ^ a1 ^ a2 ^ a3;
        mixed = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                 a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
        o_col = (i_mix ? mixed : {a0, a1, a2, a3}) ^ i_rk;
    end
endmodule

>>> src/aes_round.sv
// One pipelined AES round: four column lanes, row-shift merge, and key schedule step
module aes_round
    import aes_pkg::*;
#(
    parameter logic       MIX  = 1'b1,
    parameter logic [7:0] RCON = 8'h01
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_vld,
    input  logic [127:0] i_state,
    input  logic [127:0] i_key,
    output logic         o_vld,
    output logic [127:0] o_state,
    output logic [127:0] o_key
);
    logic [127:0] n_key, n_state;
    logic [31:0]  t;
    logic         r_vld;
    logic [127:0] r_state, r_key;

    // key schedule for this round
    always_comb begin
        t = sub_word({i_key[23:0], i_key[31:24]}) ^ {RCON, 24'h0};
        n_key[127:96] = i_key[127:96] ^ t;
        n_key[95:64]  = i_key[95:64] ^ n_key[127:96];
        n_key[63:32]  = i_key[63:32] ^ n_key[95:64];
        n_key[31:0]   = i_key[31:0] ^ n_key[63:32];
    end

    genvar c, r;
    generate
        for (c = 0; c < 4; c++) begin : g_lane
            logic [31:0] col;
            for (r = 0; r < 4; r++) begin : g_row
                // row r of column c comes from column c+r
                assign col[31-8*r -: 8] = i_state[127 - 32*((c+r)%4) - 8*r -: 8];
            end
            aes_lane u_lane (
                .i_col (col),
                .i_mix (MIX),
                .i_rk  (n_key[127-32*c -: 32]),
                .o_col (n_state[127-32*c -: 32])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_state <= n_state;
        r_key   <= n_key;
    end

    assign o_vld   = r_vld;
    assign o_state = r_state;
    assign o_key   = r_key;
endmodule

>>> src/aes128_block_encrypt.sv
// AES-128 encryption top level: key registers, whitening stage and ten-round pipeline
//
// Fully pipelined AES-128 encryptor: a block may be started every clock cycle, and
// busy is never raised. The whitening register loads at the edge that takes the start
// transfer and each round adds one register, so o_done is high once the block has passed
// the whitening register and every round register. Each round is built from four parallel
// column lanes. The receiver cannot stall; o_done lasts one cycle. The round keys travel
// down the pipeline with each block, so a key write affects blocks started after it.
module aes128_block_encrypt
    import aes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_plain      i_plain,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    output logic        o_done,
    output t_cipher     o_cipher
);
    localparam logic [7:0] RCON [NUM_ROUNDS] =
        '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

    logic [63:0]  r_key_high, r_key_low;
    logic         r_vld;
    logic [127:0] r_state, r_key;
    logic         vld   [NUM_ROUNDS+1];
    logic [127:0] state [NUM_ROUNDS+1];
    logic [127:0] key   [NUM_ROUNDS+1];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_vld      <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_KEY_HIGH) begin
                r_key_high <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == CFG_KEY_LOW) begin
                r_key_low <= i_cfg_data;
            end
            r_vld <= start;
        end
        r_state <= {i_plain.plain_high, i_plain.plain_low} ^ {r_key_high, r_key_low};
        r_key   <= {r_key_high, r_key_low};
    end

    assign vld[0]   = r_vld;
    assign state[0] = r_state;
    assign key[0]   = r_key;

    genvar g;
    generate
        for (g = 0; g < NUM_ROUNDS; g++) begin : g_round
            aes_round #(
                .MIX  ((g == NUM_ROUNDS-1) ? 1'b0 : 1'b1),
                .RCON (RCON[g])
            ) u_round (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_vld   (vld[g]),
                .i_state (state[g]),
                .i_key   (key[g]),
                .o_vld   (vld[g+1]),
                .o_state (state[g+1]),
                .o_key   (key[g+1])
            );
        end
    endgenerate

    assign o_done                = vld[NUM_ROUNDS];
    assign o_cipher.cipher_high  = state[NUM_ROUNDS][127:64];
    assign o_cipher.cipher_low   = state[NUM_ROUNDS][63:0];

`ifndef SYNTHESIS
    a_first_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> r_vld) else $error("start not captured");
    a_key_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> r_key == $past({r_key_high, r_key_low})) else $error("key not carried");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(vld[NUM_ROUNDS-1]))
        else $error("done without prior stage");
`endif
endmodule
